// ===== design/crcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfb_pkg
// Shared types, constants and the CRC byte update for the CRC16 frame builder.
// ----------------------------------------------------------------------------
package crcfb_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  HEAD_RESET  = 8'hA5;
  localparam int unsigned MAX_PAYLOAD = 32;  // legal range 1..63
  localparam int unsigned QUEUE_DEPTH = 4;

  // request mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  typedef enum logic {
    JOB_START,
    JOB_DATA
  } crcfb_kind_t;

  // one unit of work handed from the front end to the serializer
  typedef struct packed {
    crcfb_kind_t kind;
    logic [7:0]  b0;        // command id or payload byte
    logic [7:0]  b1;        // length (start only)
    logic [15:0] crc;       // running CRC after this request
    logic        with_crc;  // frame closes with this request
  } crcfb_job_t;

  // CRC16-CCITT, MSB first, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/crcfb_in_if.sv =====
// ----------------------------------------------------------------------------
// crcfb_in_if
// Request channel: start (command, length) or one payload byte.
// ----------------------------------------------------------------------------
interface crcfb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] command_id;
  logic [7:0] length;
  logic [7:0] data_byte;

  modport source (output valid, mode, command_id, length, data_byte, input ready);
  modport sink   (input valid, mode, command_id, length, data_byte, output ready);
endinterface

// ===== design/crcfb_out_if.sv =====
// ----------------------------------------------------------------------------
// crcfb_out_if
// Frame byte channel toward the link.
// ----------------------------------------------------------------------------
interface crcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== design/crcfb_front.sv =====
// ----------------------------------------------------------------------------
// crcfb_front
// Accepts requests, tracks the open frame and the running CRC, queues jobs.
// ----------------------------------------------------------------------------
module crcfb_front (
  input  logic               clk,
  input  logic               rst,
  crcfb_in_if.sink           item,
  input  logic               queue_full,
  output logic               push,
  output crcfb_pkg::crcfb_job_t push_job
);
  import crcfb_pkg::*;

  // stage 1: registered request, CRC of the command id precomputed
  logic        s1_valid;
  logic        s1_mode;
  logic [7:0]  s1_cmd;
  logic [7:0]  s1_len;
  logic [7:0]  s1_dat;
  logic [15:0] s1_crc_cmd;

  // frame state
  logic [15:0] running_crc, running_crc_next;
  logic [5:0]  bytes_left, bytes_left_next;
  logic        frame_open, frame_open_next;

  logic        advance;
  logic [15:0] crc_new;
  logic [5:0]  left_dec;

  assign advance    = s1_valid && !queue_full;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_mode    <= item.mode;
      s1_cmd     <= item.command_id;
      s1_len     <= item.length;
      s1_dat     <= item.data_byte;
      s1_crc_cmd <= crc_feed(CRC_INIT, item.command_id);
    end
  end

  // stage 2: classify and update state
  assign crc_new  = (s1_mode == MODE_START) ? crc_feed(s1_crc_cmd, s1_len)
                                            : crc_feed(running_crc, s1_dat);
  assign left_dec = bytes_left - 6'd1;

  always_comb begin
    push              = 1'b0;
    push_job.kind     = JOB_DATA;
    push_job.b0       = s1_dat;
    push_job.b1       = s1_len;
    push_job.crc      = crc_new;
    push_job.with_crc = 1'b0;
    running_crc_next  = running_crc;
    bytes_left_next   = bytes_left;
    frame_open_next   = frame_open;
    if (advance) begin
      if (s1_mode == MODE_START) begin
        if (s1_len <= 8'(MAX_PAYLOAD)) begin
          push              = 1'b1;
          push_job.kind     = JOB_START;
          push_job.b0       = s1_cmd;
          push_job.with_crc = (s1_len == 8'd0);
          running_crc_next  = crc_new;
          bytes_left_next   = s1_len[5:0];
          frame_open_next   = (s1_len != 8'd0);
        end
      end else if (frame_open) begin
        push              = 1'b1;
        push_job.with_crc = (left_dec == 6'd0);
        running_crc_next  = crc_new;
        bytes_left_next   = left_dec;
        frame_open_next   = (left_dec != 6'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      bytes_left  <= 6'd0;
      frame_open  <= 1'b0;
    end else begin
      running_crc <= running_crc_next;
      bytes_left  <= bytes_left_next;
      frame_open  <= frame_open_next;
    end
  end

  a_open_matches_count: assert property (@(posedge clk) disable iff (rst)
    frame_open == (bytes_left != 6'd0))
    else $error("frame_open out of step with bytes_left");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 6'(MAX_PAYLOAD))
    else $error("bytes_left above maximum payload");

endmodule

// ===== design/crcfb_queue.sv =====
// ----------------------------------------------------------------------------
// crcfb_queue
// Small job FIFO between the front end and the serializer.
// ----------------------------------------------------------------------------
module crcfb_queue #(
  parameter int unsigned Depth = crcfb_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crcfb_pkg::crcfb_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output crcfb_pkg::crcfb_job_t head_job
);
  import crcfb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  crcfb_job_t       entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("job queue count above depth");

endmodule

// ===== design/crcfb_back.sv =====
// ----------------------------------------------------------------------------
// crcfb_back
// Serializer: expands each job into frame bytes, one byte per cycle while the link is ready.
// ----------------------------------------------------------------------------
module crcfb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            head_byte,
  input  logic                  not_empty,
  input  crcfb_pkg::crcfb_job_t head_job,
  output logic                  pop,
  crcfb_out_if.source           frame
);
  import crcfb_pkg::*;

  logic       job_active;
  logic [7:0] job_bytes [5];
  logic [2:0] job_count;   // bytes remaining after the current one
  logic       job_crc;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_end;

  logic       emit;
  logic       last;

  assign emit = job_active && (!out_valid || frame.ready);
  assign last = (job_count == 3'd0);
  assign pop  = not_empty && (!job_active || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        job_active <= 1'b1;
      end else if (emit && last) begin
        job_active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= job_bytes[0];
      out_end  <= job_crc && last;
    end
    if (pop) begin
      job_crc <= head_job.with_crc;
      if (head_job.kind == JOB_START) begin
        job_bytes[0] <= head_byte;
        job_bytes[1] <= head_job.b0;
        job_bytes[2] <= head_job.b1;
        job_bytes[3] <= head_job.crc[7:0];
        job_bytes[4] <= head_job.crc[15:8];
        job_count    <= head_job.with_crc ? 3'd4 : 3'd2;
      end else begin
        job_bytes[0] <= head_job.b0;
        job_bytes[1] <= head_job.crc[7:0];
        job_bytes[2] <= head_job.crc[15:8];
        job_bytes[3] <= 8'h00;
        job_bytes[4] <= 8'h00;
        job_count    <= head_job.with_crc ? 3'd2 : 3'd0;
      end
    end else if (emit) begin
      for (int i = 0; i < 4; i++) begin
        job_bytes[i] <= job_bytes[i+1];
      end
      job_bytes[4] <= 8'h00;
      job_count    <= job_count - 3'd1;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.frame_end  = out_end;

  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    pop |=> job_active)
    else $error("job not active after pop");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    job_active |-> job_count <= 3'd4)
    else $error("serializer byte count out of range");

endmodule

// ===== design/crc16_frame_builder.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_builder
// Frame builder: head, command, length, payload, CRC16-CCITT low and high.
// ----------------------------------------------------------------------------
// A start request (mode 0) opens a frame and yields the head byte, command id
// and length; with length zero it also closes the frame with the CRC. Each
// payload request (mode 1) inside an open frame is echoed, and the last one
// is followed by CRC low then CRC high (frame_end set on CRC high). Starts
// with length above the maximum, and payload bytes with no frame open, are
// dropped without output. A legal-length start during an open frame abandons
// it. The CRC (init 0xFFFF, poly 0x1021, MSB first, no final XOR) covers
// command id, length and payload. Rate: a request is taken every cycle while
// the job queue has room; it is queued via the stage 1 register, and its
// first frame byte leaves from the serializer's output register. The output
// port moves one byte per cycle while the link is ready, so a start costs 3
// bytes (5 with CRC) and a payload byte 1 (3 with CRC) at the single byte-wide
// output register, which sets the sustained rate. No clearing pass after reset.
// ----------------------------------------------------------------------------
module crc16_frame_builder #(
  parameter int unsigned QueueDepth = crcfb_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  crcfb_in_if.sink   item,
  crcfb_out_if.source frame
);
  import crcfb_pkg::*;

  // head marker register; the user must write it only while idle, the block does not enforce it
  logic [7:0] head_byte;

  // front end to queue
  logic       push;
  crcfb_job_t push_job;
  logic       queue_full;

  // queue to serializer
  logic       pop;
  logic       not_empty;
  crcfb_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
    end else if (cfg_we) begin
      head_byte <= cfg_wdata;
    end
  end

  // front: request register, classification, CRC and frame state
  crcfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // decouples request intake from byte output
  crcfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  // back: byte serializer with registered output
  crcfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_byte (head_byte),
    .not_empty (not_empty),
    .head_job  (head_job),
    .pop       (pop),
    .frame     (frame)
  );

endmodule

// ===== verif/tb_crc16_frame_builder.sv =====
// ----------------------------------------------------------------------------
// tb_crc16_frame_builder
// Self-checking bench for the CRC16 frame builder. A short directed part
// covers the corner requests, then random frame traffic runs with stalls on
// both channels. Every frame byte is checked against an in-bench frame model.
// ----------------------------------------------------------------------------
module tb_crc16_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfb_pkg::*;

  localparam int unsigned IDLE_PCT     = 11;      // idle chance per cycle, percent
  localparam int unsigned LONG_HOLD    = 150;     // receiver back-pressure stretch
  localparam int unsigned DRAIN_CYCLES = 16;      // covers the front end with margin
  localparam int unsigned CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int unsigned BATCH_ITEMS  = 40;

  // one request as offered on the input channel
  typedef struct packed {
    logic       mode;
    logic [7:0] command_id;
    logic [7:0] length;
    logic [7:0] data_byte;
  } req_t;

  // one serialized byte as seen on the frame channel
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_out_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  crcfb_in_if  req_if ();
  crcfb_out_if frm_if ();

  crc16_frame_builder i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (req_if),
    .frame    (frm_if)
  );

  always #5 clk = ~clk;

  // requests waiting to be offered, and frame bytes still owed by the block
  req_t       pending_q[$];
  frame_out_t frame_bytes_q[$];

  // frame model state
  logic [7:0]  head_model;
  logic [15:0] crc_acc;
  logic [5:0]  bytes_due;
  logic        frame_live;

  // bench control
  bit          calm;         // suppresses random idling on both sides
  bit          rx_hold_req;  // asks the receiver for one long hold-off
  int unsigned rx_hold_cnt;
  bit          req_done;     // last offered request was taken at the rising edge
  req_t        drive_req;
  frame_out_t  want;

  // run statistics
  int unsigned fail_cnt;
  int unsigned req_cnt;
  int unsigned byte_cnt;
  int unsigned frame_cnt;
  int unsigned head_cnt;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Frame model
  // --------------------------------------------------------------------------

  // CRC16-CCITT, one message bit at a time, MSB first
  function automatic logic [15:0] crc_next(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // CRC low then CRC high; the high byte ends the frame
  function automatic void close_frame();
    frame_bytes_q.push_back('{crc_acc[7:0], 1'b0});
    frame_bytes_q.push_back('{crc_acc[15:8], 1'b1});
    frame_live = 1'b0;
    bytes_due  = '0;
  endfunction

  // work out the bytes that one accepted request must produce
  function automatic void predict_frame_bytes(req_t r);
    if (r.mode == MODE_START) begin
      // over-long start: dropped, an open frame stays open
      if (r.length <= MAX_PAYLOAD) begin
        crc_acc = crc_next(crc_next(CRC_INIT, r.command_id), r.length);
        frame_bytes_q.push_back('{head_model, 1'b0});
        frame_bytes_q.push_back('{r.command_id, 1'b0});
        frame_bytes_q.push_back('{r.length, 1'b0});
        if (r.length == 8'd0) begin
          close_frame();
        end else begin
          // also covers a restart: the old frame is dropped without a CRC
          bytes_due  = r.length[5:0];
          frame_live = 1'b1;
        end
      end
    end else if (frame_live) begin
      crc_acc = crc_next(crc_acc, r.data_byte);
      frame_bytes_q.push_back('{r.data_byte, 1'b0});
      bytes_due = bytes_due - 6'd1;
      if (bytes_due == '0) close_frame();
    end
    // payload with no frame open: nothing
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers; the field a mode does not use gets random content
  // --------------------------------------------------------------------------

  function automatic void push_start(logic [7:0] cmd, logic [7:0] len);
    pending_q.push_back('{MODE_START, cmd, len, 8'($urandom)});
  endfunction

  function automatic void push_data(logic [7:0] dat);
    pending_q.push_back('{MODE_DATA, 8'($urandom), 8'($urandom), dat});
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Random traffic. Mostly well-formed frames with random content, the rest
  // abandoned frames, over-long starts and stray payload bytes. Only requests
  // that the block acts on count toward n.
  task automatic gen_traffic(int unsigned n);
    int unsigned added;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // short frames dominate, a few reach the maximum
        len = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(MAX_PAYLOAD, 7);
        push_start(8'($urandom), 8'(len));
        repeat (len) push_data(8'($urandom));
        added += len + 1;
      end else if (pick < 80) begin
        // frame cut short, the next start abandons it
        len = $urandom_range(10, 2);
        cut = $urandom_range(len - 1);
        push_start(8'($urandom), 8'(len));
        repeat (cut) push_data(8'($urandom));
        added += cut + 1;
      end else if (pick < 88) begin
        push_start(8'($urandom), 8'($urandom_range(255, MAX_PAYLOAD + 1)));
      end else begin
        // usually stray, sometimes feeds an abandoned frame
        push_data(8'($urandom));
      end
    end
  endtask

  // sender pauses until every owed byte has come, then lets dropped
  // requests still in the front end fall out
  task automatic wait_idle();
    while (pending_q.size() != 0 || req_if.valid || frame_bytes_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // head byte register; only written while the block is idle
  task automatic write_head(logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    head_model = v;
    head_cnt++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge. A new request is
  // picked only after the current one was taken, so valid holds steady
  // under back-pressure.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_done) begin
      req_done = 1'b0;
      if (pending_q.size() != 0 && !idle_now()) begin
        drive_req = pending_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.mode       <= drive_req.mode;
        req_if.command_id <= drive_req.command_id;
        req_if.length     <= drive_req.length;
        req_if.data_byte  <= drive_req.data_byte;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame receiver: random idling, plus one long hold-off counted here so the
  // job queue fills and the request channel stalls.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_cnt = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (rst) begin
      frm_if.ready <= 1'b0;
    end else if (rx_hold_cnt != 0) begin
      frm_if.ready <= 1'b0;
      rx_hold_cnt--;
    end else begin
      frm_if.ready <= !idle_now();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Accepted requests feed
  // the model, accepted bytes are checked against the oldest owed byte.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      predict_frame_bytes('{req_if.mode, req_if.command_id, req_if.length,
                            req_if.data_byte});
      req_done = 1'b1;
      req_cnt++;
    end
    if (!rst && frm_if.valid && frm_if.ready) begin
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected frame byte %02h (frame_end %0b)",
               frm_if.frame_byte, frm_if.frame_end);
        fail_cnt++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (frm_if.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", want.frame_byte, frm_if.frame_byte);
          fail_cnt++;
        end
        if (frm_if.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frm_if.frame_end);
          fail_cnt++;
        end
        byte_cnt++;
        if (want.frame_end) frame_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d bytes still owed", cycle_cnt,
             frame_bytes_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_START;
    req_if.command_id = '0;
    req_if.length     = '0;
    req_if.data_byte  = '0;
    frm_if.ready      = 1'b0;
    head_model = HEAD_RESET;
    crc_acc    = CRC_INIT;
    bytes_due  = '0;
    frame_live = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, head byte at its reset value
    push_data(8'h5A);                    // payload with no frame open
    push_start(8'h00, 8'h00);            // empty frame, CRC right after header
    push_start(8'hFF, 8'h01);
    push_data(8'hFF);
    push_start(8'h12, 8'(MAX_PAYLOAD + 1));  // one past the limit
    push_start(8'h34, 8'hFF);            // longest possible length field
    push_start(8'h81, 8'h03);
    push_data(8'h00);
    push_start(8'h7E, 8'h40);            // over-long start inside an open frame
    push_data(8'h80);
    push_data(8'h01);                    // closes the 3-byte frame
    push_start(8'h55, 8'h04);
    push_data(8'hAA);
    push_start(8'hC3, 8'h02);            // restart abandons the open frame
    push_data(8'h0F);
    push_data(8'hF0);
    push_data(8'h33);                    // after close: ignored
    // one frame at the maximum length
    push_start(8'($urandom), 8'(MAX_PAYLOAD));
    repeat (MAX_PAYLOAD) push_data(8'($urandom));
    wait_idle();

    // head byte at its lower extreme
    write_head(8'h00);
    gen_traffic(BATCH_ITEMS);
    wait_idle();

    // upper extreme, with a long receiver hold-off while requests keep coming
    write_head(8'hFF);
    rx_hold_req = 1'b1;
    gen_traffic(BATCH_ITEMS);
    wait_idle();

    // random head, no idling on either side
    write_head(8'($urandom));
    calm = 1'b1;
    gen_traffic(BATCH_ITEMS);
    wait_idle();
    calm = 1'b0;

    write_head(8'($urandom));
    gen_traffic(BATCH_ITEMS);
    wait_idle();

    $display("Covered %0d requests and %0d frame bytes in %0d closed frames,",
             req_cnt, byte_cnt, frame_cnt);
    $display("over %0d head byte settings plus the reset value.", head_cnt);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
